// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file akrt_checker.sv
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, ignored while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// condition that must hold in the cycle after reset is seen
`define ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("assertion failed: state after reset");

`endif

// ===== hw/rtl/akrt_pkg.sv =====
// shared types and constants of the analog key rapid trigger
// no dependencies; used by all akrt modules and the top level
package akrt_pkg;

   // field widths
   localparam int SAMPLE_W = 10;
   localparam int TIME_W   = 16;
   localparam int DIST_W   = 10;
   localparam int TRK_W    = 14;

   // stream and register port widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_DIST    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_DIST  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_START   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTUATE_START = 2'd3;

   // reset values
   localparam logic [DIST_W-1:0] PRESS_DIST_RESET    = 10'd50;
   localparam logic [DIST_W-1:0] RELEASE_DIST_RESET  = 10'd50;
   localparam logic [TIME_W-1:0] TRACK_START_RESET   = 16'd500;
   localparam logic [TIME_W-1:0] ACTUATE_START_RESET = 16'd1000;
   localparam logic [TRK_W-1:0]  MIN_RESET           = 14'd9999;

   typedef struct packed {
      logic [DIST_W-1:0] press_dist;
      logic [DIST_W-1:0] release_dist;
      logic [TIME_W-1:0] track_start;
      logic [TIME_W-1:0] actuate_start;
   } cfg_type;

   typedef struct packed {
      logic                key;
      logic [SAMPLE_W-1:0] sample;
      logic [TIME_W-1:0]   time_ms;
   } req_type;

   // request as held in the input register, with the ring slot status
   typedef struct packed {
      req_type item;
      logic    old_valid;
   } stage_type;

   typedef struct packed {
      logic                key;
      logic                pressed;
      logic                changed;
      logic [SAMPLE_W-1:0] average;
   } rsp_type;

endpackage

// ===== hw/rtl/akrt_ring.sv =====
// input register and per-key sample ring memory with write pointers
// depends on akrt_pkg
module akrt_ring #(
   parameter int KEYS        = 2,
   parameter int WINDOW_LOG2 = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  akrt_pkg::req_type                req,
   output akrt_pkg::stage_type              stage,
   output logic [akrt_pkg::SAMPLE_W-1:0]    old_sample
);

   localparam int KEY_W  = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int DEPTH  = KEYS * (1 << WINDOW_LOG2);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [akrt_pkg::SAMPLE_W-1:0] sample_ring_ff [DEPTH];
   logic [akrt_pkg::SAMPLE_W-1:0] rd_ff;
   logic [WINDOW_LOG2-1:0]        pos_ff [KEYS];
   logic [KEYS-1:0]               filled_ff;
   akrt_pkg::stage_type           stage_ff;

   logic [KEY_W-1:0]       key_sel;
   logic                   key_ok;
   logic [WINDOW_LOG2-1:0] pos_cur;
   logic [WINDOW_LOG2-1:0] pos_in;
   logic [ADDR_W-1:0]      addr;

   // slot lookup for the incoming request
   always_comb begin
      key_sel = KEY_W'(req.key);
      key_ok  = (int'(req.key) < KEYS);
      pos_cur = pos_ff[key_sel];
      pos_in  = pos_cur + 1'b1;
      addr    = ADDR_W'({key_sel, pos_cur});
   end

   // write pointers and fill flags; a slot is read as zero until its key wraps once
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEYS; k++) begin
            pos_ff[k] <= '0;
         end
         filled_ff <= '0;
      end else if (accept && key_ok) begin
         pos_ff[key_sel] <= pos_in;
         if (pos_cur == '1) begin
            filled_ff[key_sel] <= 1'b1;
         end
      end
   end

   // read-first ring memory and input register
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff.item      <= req;
         stage_ff.old_valid <= filled_ff[key_sel];
         rd_ff              <= sample_ring_ff[addr];
         if (key_ok) begin
            sample_ring_ff[addr] <= req.sample;
         end
      end
   end

   assign stage      = stage_ff;
   assign old_sample = rd_ff;

endmodule

// ===== hw/rtl/akrt_track.sv =====
// per-key running sum, min/max tracking, press/release decision, result register
// depends on akrt_pkg
module akrt_track #(
   parameter int KEYS        = 2,
   parameter int WINDOW_LOG2 = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  akrt_pkg::stage_type           stage,
   input  logic [akrt_pkg::SAMPLE_W-1:0] old_sample,
   input  akrt_pkg::cfg_type             cfg,
   output akrt_pkg::rsp_type             rsp
);

   localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int SUM_W = akrt_pkg::SAMPLE_W + WINDOW_LOG2;
   localparam int CMP_W = akrt_pkg::TRK_W + 1;
   localparam int REL_W = akrt_pkg::SAMPLE_W + 1;

   logic [SUM_W-1:0]              sum_ff [KEYS];
   logic [akrt_pkg::TRK_W-1:0]    min_ff [KEYS];
   logic [akrt_pkg::SAMPLE_W-1:0] max_ff [KEYS];
   logic [KEYS-1:0]               down_ff;
   akrt_pkg::rsp_type             rsp_ff;

   logic [KEY_W-1:0]              key_sel;
   logic                          key_ok;
   logic [akrt_pkg::SAMPLE_W-1:0] smp;
   logic [akrt_pkg::SAMPLE_W-1:0] old;
   logic [SUM_W-1:0]              sum_in;
   logic [akrt_pkg::SAMPLE_W-1:0] avg;
   logic                          track_on;
   logic                          act_on;
   logic [akrt_pkg::TRK_W-1:0]    min_t;
   logic [akrt_pkg::SAMPLE_W-1:0] max_t;
   logic                          press_hit;
   logic [akrt_pkg::SAMPLE_W-1:0] max_p;
   logic                          rel_hit;
   logic                          was_down;
   logic [akrt_pkg::TRK_W-1:0]    min_in;
   logic [akrt_pkg::SAMPLE_W-1:0] max_in;
   logic                          down_in;
   akrt_pkg::rsp_type             rsp_in;

   // running sum and average
   always_comb begin
      key_sel = KEY_W'(stage.item.key);
      key_ok  = (int'(stage.item.key) < KEYS);
      smp     = stage.item.sample;
      old     = stage.old_valid ? old_sample : '0;
      sum_in  = sum_ff[key_sel] + SUM_W'(smp) - SUM_W'(old);
      avg     = sum_in[SUM_W-1:WINDOW_LOG2];
   end

   // min/max follow the average, then press and release tests on the raw sample
   always_comb begin
      track_on  = (stage.item.time_ms >= cfg.track_start);
      act_on    = track_on && (stage.item.time_ms >= cfg.actuate_start);
      was_down  = down_ff[key_sel];
      min_t     = (akrt_pkg::TRK_W'(avg) < min_ff[key_sel]) ?
                  akrt_pkg::TRK_W'(avg) : min_ff[key_sel];
      max_t     = (avg > max_ff[key_sel]) ? avg : max_ff[key_sel];
      press_hit = (CMP_W'(smp) >= CMP_W'(min_t) + CMP_W'(cfg.press_dist));
      max_p     = press_hit ? smp : max_t;
      rel_hit   = (REL_W'(max_p) >= REL_W'(smp) + REL_W'(cfg.release_dist));

      min_in  = min_ff[key_sel];
      max_in  = max_ff[key_sel];
      down_in = was_down;
      if (track_on) begin
         min_in = min_t;
         max_in = max_t;
         if (act_on) begin
            if (press_hit) begin
               down_in = 1'b1;
               max_in  = smp;
            end
            if (rel_hit) begin
               down_in = 1'b0;
               min_in  = akrt_pkg::TRK_W'(smp);
            end
         end
      end
   end

   // result; an unknown key reports zeros
   always_comb begin
      rsp_in.key = stage.item.key;
      if (key_ok) begin
         rsp_in.pressed = down_in;
         rsp_in.changed = down_in ^ was_down;
         rsp_in.average = avg;
      end else begin
         rsp_in.pressed = 1'b0;
         rsp_in.changed = 1'b0;
         rsp_in.average = '0;
      end
   end

   // per-key state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEYS; k++) begin
            sum_ff[k] <= '0;
            min_ff[k] <= akrt_pkg::MIN_RESET;
            max_ff[k] <= '0;
         end
         down_ff <= '0;
      end else if (advance && key_ok) begin
         sum_ff[key_sel]  <= sum_in;
         min_ff[key_sel]  <= min_in;
         max_ff[key_sel]  <= max_in;
         down_ff[key_sel] <= down_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ===== hw/rtl/analog_key_rapid_trigger.sv =====
// Analog key rapid trigger: moving average, min/max tracking, press/release per key.
// Path from request accept to response valid: input register with the ring memory
// read, then the result register. Throughput: one request per cycle while the
// response side is not stalled, set by the single read-first port of the sample ring memory.
// Reset (synchronous): clears handshake state, per-key sums, max, key state and ring
// pointers, sets min to MIN_RESET, loads register defaults; ring contents read as zero until filled.
module analog_key_rapid_trigger #(
   parameter int KEYS        = 2,
   parameter int WINDOW_LOG2 = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [akrt_pkg::REQ_DATA_W-1:0]   req_tdata,   // sample[9:0], time_ms[25:10], zero pad
   input  logic                              req_tuser,   // key_index[0]
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [akrt_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // pressed[0], changed[1], average[11:2], zero pad
   output logic                              rsp_tuser,   // out_key[0]
   // register writes
   input  logic                              csr_we,
   input  logic [akrt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [akrt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   akrt_pkg::cfg_type   cfg_ff;
   logic                s1_valid_ff;
   logic                rsp_valid_ff;
   logic                s1_valid_in;
   logic                rsp_valid_in;

   logic                rsp_free;
   logic                advance;
   logic                accept;
   akrt_pkg::req_type   req;
   akrt_pkg::stage_type stage;
   akrt_pkg::rsp_type   rsp;
   logic [akrt_pkg::SAMPLE_W-1:0] old_sample;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_dist    <= akrt_pkg::PRESS_DIST_RESET;
         cfg_ff.release_dist  <= akrt_pkg::RELEASE_DIST_RESET;
         cfg_ff.track_start   <= akrt_pkg::TRACK_START_RESET;
         cfg_ff.actuate_start <= akrt_pkg::ACTUATE_START_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            akrt_pkg::CSR_PRESS_DIST: begin
               cfg_ff.press_dist <= csr_wdata[akrt_pkg::DIST_W-1:0];
            end
            akrt_pkg::CSR_RELEASE_DIST: begin
               cfg_ff.release_dist <= csr_wdata[akrt_pkg::DIST_W-1:0];
            end
            akrt_pkg::CSR_TRACK_START: begin
               cfg_ff.track_start <= csr_wdata[akrt_pkg::TIME_W-1:0];
            end
            akrt_pkg::CSR_ACTUATE_START: begin
               cfg_ff.actuate_start <= csr_wdata[akrt_pkg::TIME_W-1:0];
            end
         endcase
      end
   end

   // handshake: the result register frees the input register, which frees the request side
   always_comb begin
      rsp_free     = !rsp_valid_ff || rsp_tready;
      advance      = s1_valid_ff && rsp_free;
      req_tready   = !s1_valid_ff || rsp_free;
      accept       = req_tvalid && req_tready;
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request unpack
   always_comb begin
      req.key     = req_tuser;
      req.sample  = req_tdata[akrt_pkg::SAMPLE_W-1:0];
      req.time_ms = req_tdata[akrt_pkg::SAMPLE_W +: akrt_pkg::TIME_W];
   end

   akrt_ring #(
      .KEYS        (KEYS),
      .WINDOW_LOG2 (WINDOW_LOG2)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req),
      .stage      (stage),
      .old_sample (old_sample)
   );

   akrt_track #(
      .KEYS        (KEYS),
      .WINDOW_LOG2 (WINDOW_LOG2)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .stage      (stage),
      .old_sample (old_sample),
      .cfg        (cfg_ff),
      .rsp        (rsp)
   );

   // response pack
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp.key;
   assign rsp_tdata  = {
      (akrt_pkg::RSP_DATA_W - akrt_pkg::SAMPLE_W - 2)'(0),
      rsp.average, rsp.changed, rsp.pressed
   };

endmodule

// ===== hw/rtl/akrt_checker.sv =====
// port-level checks for the analog key rapid trigger, bound to the top level
// depends on akrt_pkg and assert_macros.svh
`include "assert_macros.svh"

module akrt_checker #(
   parameter int KEYS = 2
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [akrt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   // no response is pending right after reset
   `ASSERT_AFTER_RESET(a_idle_after_reset, clock, reset, !rsp_tvalid)

   // a stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // with the result register empty the block always takes a request
   `ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // rsp_tvalid is high once an accepted request has passed the input register and the result register
   `ASSERT_IMPLIES(a_latency, clock, reset, req_tvalid && req_tready, ##2 rsp_tvalid)

   // a key beyond the configured count reports all zeros
   `ASSERT_IMPLIES(a_unknown_key, clock, reset, rsp_tvalid && (int'(rsp_tuser) >= KEYS), rsp_tdata == '0)

endmodule

bind analog_key_rapid_trigger akrt_checker #(.KEYS(KEYS)) u_akrt_checker (.*);

// ===== dv/tb_analog_key_rapid_trigger.sv =====
// self-checking testbench for analog_key_rapid_trigger: per-key moving average and rapid trigger
// depends on akrt_pkg and the analog_key_rapid_trigger rtl; no other files
`timescale 1ns / 1ps

module tb_analog_key_rapid_trigger;

   localparam int RING_DEPTH  = 16;
   localparam int AVG_SHIFT   = 4;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [akrt_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            req_tuser  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [akrt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_we     = 1'b0;
   logic [akrt_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [akrt_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   analog_key_rapid_trigger uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // request and report stores
   akrt_pkg::req_type pending_samples[$];
   akrt_pkg::rsp_type expected_reports[$];
   akrt_pkg::req_type offered_sample;
   akrt_pkg::rsp_type oldest_report;
   int      error_count    = 0;
   int      accepted_count = 0;

   // shadow of the key state and the registers
   akrt_pkg::cfg_type trigger_cfg;
   int          ring_samples [2][RING_DEPTH];
   int          ring_slot    [2];
   int          window_sum   [2];
   int          low_mark     [2];
   int          high_mark    [2];
   logic        key_down     [2];

   // stroke generator state
   int          stroke_level [2];
   int          stroke_goal  [2];
   logic [15:0] stroke_clock [2];

   // one sample through the per-key average and trigger logic
   function automatic akrt_pkg::rsp_type key_update(akrt_pkg::req_type r);
      akrt_pkg::rsp_type res;
      int      k;
      int      s;
      int      avg;
      int      slot;
      logic    was_down;
      k = r.key;
      s = int'(r.sample);
      slot = ring_slot[k];
      window_sum[k] = window_sum[k] + s - ring_samples[k][slot];
      ring_samples[k][slot] = s;
      avg = window_sum[k] >>> AVG_SHIFT;
      ring_slot[k] = (slot + 1) % RING_DEPTH;
      was_down = key_down[k];
      if (r.time_ms >= trigger_cfg.track_start) begin
         if (avg < low_mark[k]) low_mark[k] = avg;
         if (avg > high_mark[k]) high_mark[k] = avg;
         if (r.time_ms >= trigger_cfg.actuate_start) begin
            // press is tested first, then release against the updated max
            if (s - low_mark[k] >= int'(trigger_cfg.press_dist)) begin
               key_down[k] = 1'b1;
               high_mark[k] = s;
            end
            if (high_mark[k] - s >= int'(trigger_cfg.release_dist)) begin
               key_down[k] = 1'b0;
               low_mark[k] = s;
            end
         end
      end
      res.key = r.key;
      res.pressed = key_down[k];
      res.changed = (key_down[k] != was_down);
      res.average = avg[akrt_pkg::SAMPLE_W-1:0];
      return res;
   endfunction

   task automatic add_sample(input int k, input int smp, input int t);
      akrt_pkg::req_type r;
      r.key = k[0];
      r.sample = smp[akrt_pkg::SAMPLE_W-1:0];
      r.time_ms = t[akrt_pkg::TIME_W-1:0];
      pending_samples.push_back(r);
   endtask

   // wait until every request is taken and every report has come back
   // sampled away from the rising edge so the driver's updates have settled
   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_tvalid || expected_reports.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [akrt_pkg::CSR_IDX_W-1:0] idx, input int val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[akrt_pkg::CSR_DATA_W-1:0];
      case (idx)
         akrt_pkg::CSR_PRESS_DIST:
            trigger_cfg.press_dist    = val[akrt_pkg::DIST_W-1:0];
         akrt_pkg::CSR_RELEASE_DIST:
            trigger_cfg.release_dist  = val[akrt_pkg::DIST_W-1:0];
         akrt_pkg::CSR_TRACK_START:
            trigger_cfg.track_start   = val[akrt_pkg::TIME_W-1:0];
         akrt_pkg::CSR_ACTUATE_START:
            trigger_cfg.actuate_start = val[akrt_pkg::TIME_W-1:0];
         default: ;
      endcase
   endtask

   // registers change only once the block is drained
   task automatic apply_settings(input int press, input int rel, input int track,
                                 input int actuate);
      wait_drained();
      write_reg(akrt_pkg::CSR_PRESS_DIST, press);
      write_reg(akrt_pkg::CSR_RELEASE_DIST, rel);
      write_reg(akrt_pkg::CSR_TRACK_START, track);
      write_reg(akrt_pkg::CSR_ACTUATE_START, actuate);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // key strokes: each key's level swings between random goals with jitter, mixed with fully random samples
   task automatic make_strokes(input int count);
      int k;
      int delta;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 1);
         if ($urandom_range(0, 99) < 15) begin
            add_sample(k, $urandom_range(0, 1023), $urandom_range(0, 65535));
         end else begin
            stroke_clock[k] = stroke_clock[k] + 16'($urandom_range(1, 25));
            if (stroke_level[k] == stroke_goal[k]) begin
               if (stroke_goal[k] > 511) stroke_goal[k] = $urandom_range(0, 300);
               else stroke_goal[k] = $urandom_range(600, 1023);
            end
            delta = stroke_goal[k] - stroke_level[k];
            if (delta > 100) delta = $urandom_range(20, 100);
            else if (delta < -100) delta = -$urandom_range(20, 100);
            stroke_level[k] = stroke_level[k] + delta;
            add_sample(k, stroke_level[k], stroke_clock[k]);
         end
      end
   endtask

   // request driver: bursts of random length with random gaps
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_reports.push_back(key_update(offered_sample));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               offered_sample = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {6'b0, offered_sample.time_ms, offered_sample.sample};
               req_tuser  <= offered_sample.key;
               burst_left--;
               if (burst_left <= 0) begin
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                           : $urandom_range(1, 12);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // report monitor and receiver stall pattern
   int ready_mode = 0;
   int mode_left  = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               $error("report with no request outstanding: key %0d data %h",
                      rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               oldest_report = expected_reports.pop_front();
               if (rsp_tuser !== oldest_report.key) begin
                  $error("out_key: expected %0d actual %0d", oldest_report.key, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[0] !== oldest_report.pressed) begin
                  $error("pressed: expected %0d actual %0d", oldest_report.pressed,
                         rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[1] !== oldest_report.changed) begin
                  $error("changed: expected %0d actual %0d", oldest_report.changed,
                         rsp_tdata[1]);
                  error_count++;
               end
               if (rsp_tdata[11:2] !== oldest_report.average) begin
                  $error("average: expected %0d actual %0d", oldest_report.average,
                         rsp_tdata[11:2]);
                  error_count++;
               end
            end
         end
         // one long hold-off while the sender keeps offering
         if (!hold_done && accepted_count >= 400) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = $urandom_range(0, 2);
               mode_left = $urandom_range(5, 60);
            end else begin
               mode_left--;
            end
            case (ready_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 1) == 1);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // watchdog on cycles with no handshake on either stream
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin
      trigger_cfg.press_dist    = akrt_pkg::PRESS_DIST_RESET;
      trigger_cfg.release_dist  = akrt_pkg::RELEASE_DIST_RESET;
      trigger_cfg.track_start   = akrt_pkg::TRACK_START_RESET;
      trigger_cfg.actuate_start = akrt_pkg::ACTUATE_START_RESET;
      for (int k = 0; k < 2; k++) begin
         for (int i = 0; i < RING_DEPTH; i++) ring_samples[k][i] = 0;
         ring_slot[k] = 0;
         window_sum[k] = 0;
         low_mark[k] = int'(akrt_pkg::MIN_RESET);
         high_mark[k] = 0;
         key_down[k] = 1'b0;
         stroke_level[k] = 0;
         stroke_goal[k] = 800;
         stroke_clock[k] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: ring fill, tracking start, press, release, timer wrap
      add_sample(0, 0, 0);
      add_sample(1, 1023, 0);
      add_sample(0, 1023, 100);
      add_sample(0, 1023, 499);
      add_sample(0, 1023, 500);
      add_sample(0, 0, 999);
      add_sample(0, 0, 1000);
      add_sample(0, 1023, 1000);
      add_sample(0, 0, 1001);
      add_sample(1, 512, 65535);
      add_sample(1, 1023, 65535);
      add_sample(1, 0, 65535);
      add_sample(1, 1023, 0);
      add_sample(1, 341, 682);

      // zero distances, actuation set before tracking
      apply_settings(0, 0, 3000, 100);
      add_sample(1, 700, 50);
      add_sample(1, 700, 150);
      add_sample(1, 900, 3000);
      add_sample(1, 100, 3001);
      add_sample(0, 600, 3500);
      add_sample(0, 600, 3501);

      // widest distances, tracking and actuation from time zero
      apply_settings(1023, 1023, 0, 0);
      add_sample(0, 1023, 0);
      add_sample(0, 0, 1);
      add_sample(1, 1023, 2);

      // smallest nonzero distances, thresholds at the top of the timer
      apply_settings(1, 1, 65535, 65535);
      add_sample(0, 5, 65534);
      add_sample(0, 900, 65535);
      add_sample(1, 0, 65535);

      // random phases of key strokes with noise
      for (int phase = 0; phase < 7; phase++) begin
         apply_settings(($urandom_range(0, 7) == 0) ? $urandom_range(1, 1023)
                                                    : $urandom_range(5, 200),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1023)
                                                    : $urandom_range(5, 200),
                        $urandom_range(0, 1500), $urandom_range(0, 2500));
         for (int k = 0; k < 2; k++)
            stroke_clock[k] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(64800, 65500))
                                                          : 16'($urandom_range(0, 1200));
         make_strokes(150);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (expected_reports.size() != 0) begin
         $error("%0d reports never arrived", expected_reports.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/akrt_pkg.sv
hw/rtl/akrt_ring.sv
hw/rtl/akrt_track.sv
hw/rtl/analog_key_rapid_trigger.sv
hw/rtl/akrt_checker.sv
dv/tb_analog_key_rapid_trigger.sv
